/* hdl/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check of an implication, same or next cycle written into the property.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check of a consequence in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cltok_pkg.sv */
// Shared types and character codes for the line and word tokenizer.
// No dependencies; imported by cltok_core, cltok_obuf and the top level.
`default_nettype none

package cltok_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam int unsigned LEN_SAT = 255;
    localparam int unsigned LNUM_W  = 24;

    // One result beat.
    typedef struct packed {
        logic              char_valid;
        logic [7:0]        word_char;
        logic              word_end;
        logic [7:0]        word_length;
        logic              line_end;
        logic              line_overflow;
        logic              end_of_data;
        logic [LNUM_W-1:0] line_number;
    } res_t;

    // Result handed from the tokenizer core to the output buffer.
    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

endpackage

`default_nettype wire

/* hdl/cltok_core.sv */
// Tokenizer state registers and the combinational next-state / result logic.
// Depends on cltok_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cltok_core #(
    parameter int unsigned LINE_LIMIT       = 256,
    parameter int unsigned WORD_LIMIT       = 255,
    parameter int unsigned LINE_NUMBER_BITS = 24
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           end_of_file,
    output cltok_pkg::push_t    push
);
    import cltok_pkg::*;

    localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 1);
    localparam int unsigned WC_W  = $clog2(WORD_LIMIT + 1);

    logic                        quotes_reg, quotes_next;
    logic                        swallow_reg, swallow_next;
    logic                        comment_reg, comment_next;
    logic [LEN_W-1:0]            llen_reg, llen_next;
    logic [WC_W-1:0]             wcnt_reg, wcnt_next;
    logic                        ovf_reg, ovf_next;
    logic                        lsp_reg, lsp_next;
    logic [LINE_NUMBER_BITS-1:0] ctr_reg, ctr_next;

    logic        finish;
    logic        eod;
    logic        is_sep;
    logic        is_eol;
    logic [31:0] wcnt_ext;
    logic [31:0] ctr_ext;
    logic [7:0]  wlen_sat;

    assign is_sep   = (data_byte == CH_SPACE) || (data_byte == CH_COMMA)
                   || (data_byte == CH_TAB);
    assign is_eol   = (data_byte == CH_LF) || (data_byte == CH_CR);
    assign wcnt_ext = 32'(wcnt_reg);
    assign wlen_sat = (wcnt_ext > LEN_SAT) ? 8'(LEN_SAT) : wcnt_ext[7:0];
    assign ctr_ext  = 32'(ctr_next);

    always_comb begin
        quotes_next  = quotes_reg;
        swallow_next = swallow_reg;
        comment_next = comment_reg;
        llen_next    = llen_reg;
        wcnt_next    = wcnt_reg;
        ovf_next     = ovf_reg;
        lsp_next     = lsp_reg;
        ctr_next     = ctr_reg;
        finish       = 1'b0;
        eod          = 1'b0;
        push                   = '0;
        push.res.line_overflow = ovf_reg;

        if (end_of_file) begin
            swallow_next = 1'b0;
            comment_next = 1'b0;
            finish       = 1'b1;
            eod          = 1'b1;
        end else if (swallow_reg) begin
            swallow_next = 1'b0;
        end else if (comment_reg) begin
            if (is_eol || data_byte == CH_NUL) begin
                comment_next = 1'b0;
                lsp_next     = 1'b1;
                if (data_byte == CH_CR) begin
                    swallow_next = 1'b1;
                end
            end
        end else if (data_byte == CH_NUL) begin
            finish = 1'b1;
            eod    = 1'b1;
        end else begin
            if (lsp_reg) begin
                ctr_next = ctr_reg + LINE_NUMBER_BITS'(1);
                lsp_next = 1'b0;
            end
            if (is_eol) begin
                if (data_byte == CH_CR) begin
                    swallow_next = 1'b1;
                end
                if (llen_reg == '0) begin
                    lsp_next = 1'b1;
                end else begin
                    finish = 1'b1;
                end
            end else if (data_byte == CH_SEMI && llen_reg == '0) begin
                comment_next = 1'b1;
            end else if (llen_reg >= LEN_W'(LINE_LIMIT)) begin
                ovf_next = 1'b1;
            end else begin
                llen_next = llen_reg + LEN_W'(1);
                if (is_sep && !quotes_reg) begin
                    if (wcnt_reg != '0) begin
                        push.valid            = 1'b1;
                        push.res.word_end     = 1'b1;
                        push.res.word_length  = wlen_sat;
                        wcnt_next             = '0;
                    end
                end else if (data_byte == CH_QUOTE) begin
                    quotes_next = !quotes_reg;
                end else if (wcnt_reg >= WC_W'(WORD_LIMIT)) begin
                    ovf_next = 1'b1;
                end else begin
                    wcnt_next           = wcnt_reg + WC_W'(1);
                    push.valid          = 1'b1;
                    push.res.char_valid = 1'b1;
                    push.res.word_char  = data_byte;
                end
            end
        end

        if (finish) begin
            push.valid           = 1'b1;
            push.res.word_end    = (wcnt_reg != '0);
            push.res.word_length = (wcnt_reg != '0) ? wlen_sat : 8'd0;
            push.res.line_end    = (llen_reg != '0);
            push.res.end_of_data = eod;
            quotes_next = 1'b0;
            llen_next   = '0;
            wcnt_next   = '0;
            ovf_next    = 1'b0;
            lsp_next    = 1'b1;
        end

        push.res.line_number = ctr_ext[LNUM_W-1:0];
        push.valid           = push.valid & accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quotes_reg  <= 1'b0;
            swallow_reg <= 1'b0;
            comment_reg <= 1'b0;
            llen_reg    <= '0;
            wcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            lsp_reg     <= 1'b1;
            ctr_reg     <= '1;
        end else if (accept) begin
            quotes_reg  <= quotes_next;
            swallow_reg <= swallow_next;
            comment_reg <= comment_next;
            llen_reg    <= llen_next;
            wcnt_reg    <= wcnt_next;
            ovf_reg     <= ovf_next;
            lsp_reg     <= lsp_next;
            ctr_reg     <= ctr_next;
        end
    end

    `ASSERT_ALWAYS(a_wcnt_limit, aclk, aresetn, wcnt_reg <= WC_W'(WORD_LIMIT), "word count over limit")
    `ASSERT_IMPLY(a_comment_empty, aclk, aresetn, comment_reg, llen_reg == '0, "comment on nonempty line")
    `ASSERT_IMPLY(a_quote_stored, aclk, aresetn, quotes_reg, llen_reg != '0, "quoting with empty line")
    `ASSERT_IMPLY(a_word_stored, aclk, aresetn, wcnt_reg != '0, llen_reg >= LEN_W'(wcnt_reg), "word longer than line")

endmodule

`default_nettype wire

/* hdl/cltok_obuf.sv */
// Output register plus one skid entry for the result channel.
// Depends on cltok_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cltok_obuf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cltok_pkg::push_t  push,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cltok_pkg::res_t        out_res
);
    import cltok_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_reg       <= push.res;
                out_valid_reg <= push.valid;
            end
        end else if (push.valid) begin
            skid_reg       <= push.res;
            skid_valid_reg <= 1'b1;
        end
    end

    `ASSERT_IMPLY(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `ASSERT_NEXT(a_skid_fill, aclk, aresetn, out_valid_reg && !out_ready && push.valid, skid_valid_reg, "stalled beat lost")
    `ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg, "skid not drained")

endmodule

`default_nettype wire

/* hdl/config_text_line_word_tokenizer.sv */
// Top level of the text line and word tokenizer.
// Depends on cltok_pkg, cltok_core and cltok_obuf.
//
// Takes one text byte per beat and turns it into at most one result beat:
// a word character, a word end with its length (saturating at 255), a line
// end, or end of data. Empty lines are dropped; a ';' as the first stored
// byte of a line makes a comment up to LF, CR or zero; a CR swallows the
// byte after it; space, comma and tab split words outside double quotes,
// and quote marks are dropped. s_end_of_file, or a zero byte that is
// neither swallowed nor in a comment, ends the text. line_number is the
// zero based physical line, low 24 bits of a LINE_NUMBER_BITS counter.
// Rate: one input beat per clock while s_ready is high. The state update
// is a single pass of logic between the state registers; a result is
// registered in the output register, or in one skid entry if m_ready stalls;
// s_ready drops only once both hold a beat.
`default_nettype none

module config_text_line_word_tokenizer #(
    parameter int unsigned LINE_LIMIT       = 256,
    parameter int unsigned WORD_LIMIT       = 255,
    parameter int unsigned LINE_NUMBER_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_file,
    // result beats
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_char_valid,
    output logic [7:0]       m_word_char,
    output logic             m_word_end,
    output logic [7:0]       m_word_length,
    output logic             m_line_end,
    output logic             m_line_overflow,
    output logic             m_end_of_data,
    output logic [23:0]      m_line_number
);
    import cltok_pkg::*;

    logic  accept;
    push_t push;
    res_t  res;

    // An input beat moves when the buffer has room for its possible result.
    assign accept = s_valid && s_ready;

    cltok_core #(
        .LINE_LIMIT       (LINE_LIMIT),
        .WORD_LIMIT       (WORD_LIMIT),
        .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .end_of_file (s_end_of_file),
        .push        (push)
    );

    cltok_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_char_valid    = res.char_valid;
    assign m_word_char     = res.word_char;
    assign m_word_end      = res.word_end;
    assign m_word_length   = res.word_length;
    assign m_line_end      = res.line_end;
    assign m_line_overflow = res.line_overflow;
    assign m_end_of_data   = res.end_of_data;
    assign m_line_number   = res.line_number;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for config_text_line_word_tokenizer.
// Depends on cltok_pkg (character codes, res_t) and the tokenizer RTL.
// Holds its own model of the tokenizer; random byte streams, random stalls.
`default_nettype none

module testbench;
    import cltok_pkg::*;

    // Input beats to reach before the random stream stops.
    localparam int unsigned ITEMS_TARGET = 1850;
    // Cycles the receiver holds off during each long stall.
    localparam int unsigned LONG_HOLD    = 250;

    // ------------------------------------------------------------------
    // Token ledger: tracks tokenizer state, predicts the result beat, if any,
    // that each accepted byte causes, and checks result beats in order.
    // ------------------------------------------------------------------
    class token_ledger;
        localparam int unsigned LINE_CAP = 256;
        localparam int unsigned WORD_CAP = 255;

        bit                quoting, skip_next, comment_body, line_fresh, dropped;
        int unsigned       line_bytes, word_chars;
        logic [LNUM_W-1:0] line_ctr;
        res_t              awaited_tokens[$];
        int unsigned       bytes_taken, bytes_ignored, tokens_seen, mismatches;
        int unsigned       words_seen, lines_seen, ends_seen, overflow_tokens;

        function new();
            quoting      = 1'b0;
            skip_next    = 1'b0;
            comment_body = 1'b0;
            line_fresh   = 1'b1;
            dropped      = 1'b0;
            line_bytes   = 0;
            word_chars   = 0;
            line_ctr     = '1;
            bytes_taken  = 0;
            bytes_ignored = 0;
            tokens_seen  = 0;
            mismatches   = 0;
            words_seen   = 0;
            lines_seen   = 0;
            ends_seen    = 0;
            overflow_tokens = 0;
        endfunction

        // Every result carries the overflow flag and the current line number.
        function res_t fresh_token();
            res_t t;
            t = '0;
            t.line_overflow = dropped;
            t.line_number   = line_ctr;
            return t;
        endfunction

        // Line end or end of data: pending word and nonempty line finish together.
        function void close_line(bit eod);
            res_t t;
            t = fresh_token();
            if (word_chars != 0) begin
                t.word_end    = 1'b1;
                t.word_length = (word_chars > LEN_SAT) ? 8'(LEN_SAT) : 8'(word_chars);
            end
            t.line_end    = (line_bytes != 0);
            t.end_of_data = eod;
            awaited_tokens.push_back(t);
            quoting    = 1'b0;
            line_bytes = 0;
            word_chars = 0;
            dropped    = 1'b0;
            line_fresh = 1'b1;
        endfunction

        function void take_byte(logic [7:0] b, logic eof);
            res_t t;
            bytes_taken++;
            if (eof) begin
                skip_next    = 1'b0;
                comment_body = 1'b0;
                close_line(1'b1);
                return;
            end
            if (skip_next) begin
                skip_next = 1'b0;
                bytes_ignored++;
                return;
            end
            if (comment_body) begin
                if (b == CH_LF || b == CH_NUL || b == CH_CR) begin
                    comment_body = 1'b0;
                    line_fresh   = 1'b1;
                    skip_next    = (b == CH_CR);
                end else begin
                    bytes_ignored++;
                end
                return;
            end
            if (b == CH_NUL) begin
                close_line(1'b1);
                return;
            end
            if (line_fresh) begin
                line_ctr++;
                line_fresh = 1'b0;
            end
            if (b == CH_LF || b == CH_CR) begin
                skip_next = (b == CH_CR);
                if (line_bytes == 0)
                    line_fresh = 1'b1;
                else
                    close_line(1'b0);
                return;
            end
            if (b == CH_SEMI && line_bytes == 0) begin
                comment_body = 1'b1;
                return;
            end
            if (line_bytes >= LINE_CAP) begin
                dropped = 1'b1;
                bytes_ignored++;
                return;
            end
            line_bytes++;
            if ((b == CH_SPACE || b == CH_COMMA || b == CH_TAB) && !quoting) begin
                if (word_chars != 0) begin
                    t = fresh_token();
                    t.word_end    = 1'b1;
                    t.word_length = (word_chars > LEN_SAT) ? 8'(LEN_SAT) : 8'(word_chars);
                    awaited_tokens.push_back(t);
                    word_chars = 0;
                end
                return;
            end
            if (b == CH_QUOTE) begin
                quoting = !quoting;
                return;
            end
            if (word_chars >= WORD_CAP) begin
                dropped = 1'b1;
                bytes_ignored++;
                return;
            end
            word_chars++;
            t = fresh_token();
            t.char_valid = 1'b1;
            t.word_char  = b;
            awaited_tokens.push_back(t);
        endfunction

        function string show(res_t t);
            return $sformatf("cv=%0b ch=%02h we=%0b wl=%0d le=%0b ov=%0b eod=%0b ln=%0d",
                             t.char_valid, t.word_char, t.word_end, t.word_length,
                             t.line_end, t.line_overflow, t.end_of_data, t.line_number);
        endfunction

        function void match_token(res_t got);
            res_t  exp;
            string bad;
            if (awaited_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", show(got));
                return;
            end
            exp = awaited_tokens.pop_front();
            tokens_seen++;
            words_seen      += exp.word_end;
            lines_seen      += exp.line_end;
            ends_seen       += exp.end_of_data;
            overflow_tokens += exp.line_overflow;
            bad = "";
            if (got.char_valid    !== exp.char_valid)    bad = {bad, " char_valid"};
            if (got.word_char     !== exp.word_char)     bad = {bad, " word_char"};
            if (got.word_end      !== exp.word_end)      bad = {bad, " word_end"};
            if (got.word_length   !== exp.word_length)   bad = {bad, " word_length"};
            if (got.line_end      !== exp.line_end)      bad = {bad, " line_end"};
            if (got.line_overflow !== exp.line_overflow) bad = {bad, " line_overflow"};
            if (got.end_of_data   !== exp.end_of_data)   bad = {bad, " end_of_data"};
            if (got.line_number   !== exp.line_number)   bad = {bad, " line_number"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d in%s\n  expected %s\n  actual   %s",
                             tokens_seen, bad, show(exp), show(got));
            end
        endfunction

        function bit failed();
            return mismatches != 0 || awaited_tokens.size() != 0;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, ports and the block under test
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_end_of_file;
    logic        m_valid;
    logic        m_ready;
    logic        m_char_valid;
    logic [7:0]  m_word_char;
    logic        m_word_end;
    logic [7:0]  m_word_length;
    logic        m_line_end;
    logic        m_line_overflow;
    logic        m_end_of_data;
    logic [23:0] m_line_number;

    token_ledger ledger = new();

    // Bytes waiting to be sent; bit 8 marks an end-of-file beat.
    logic [8:0]  beat_q[$];
    // When set, the sender offers beats back to back with no gaps.
    bit          src_steady;

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    config_text_line_word_tokenizer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_valid    (m_char_valid),
        .m_word_char     (m_word_char),
        .m_word_end      (m_word_end),
        .m_word_length   (m_word_length),
        .m_line_end      (m_line_end),
        .m_line_overflow (m_line_overflow),
        .m_end_of_data   (m_end_of_data),
        .m_line_number   (m_line_number)
    );

    // Idle length: mostly none, sometimes short, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the rising edge, before any
    // register in the block updates. The input beat is noted first so a
    // result can never be checked ahead of the byte that caused it.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : beat_monitor
        res_t got;
        if (aresetn) begin
            if (s_valid && s_ready)
                ledger.take_byte(s_data_byte, s_end_of_file);
            if (m_valid && m_ready) begin
                got = {m_char_valid, m_word_char, m_word_end, m_word_length, m_line_end,
                       m_line_overflow, m_end_of_data, m_line_number};
                ledger.match_token(got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, steady stretches, and two long hold-offs
    // triggered by result count. During a hold the sender keeps offering,
    // so the output register and skid entry fill and s_ready drops.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall, hold, holds_done, steady_left;
        bit          sink_steady;
        stall       = 0;
        hold        = 0;
        holds_done  = 0;
        steady_left = 0;
        sink_steady = 1'b0;
        m_ready     = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (steady_left == 0) begin
                sink_steady = ($urandom_range(0, 4) == 0);
                steady_left = $urandom_range(50, 200);
            end
            steady_left--;
            if (hold == 0 && holds_done < 2 &&
                ledger.tokens_seen >= ((holds_done == 0) ? 300 : 1100)) begin
                hold = LONG_HOLD;
                holds_done++;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!sink_steady)
                    stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. Inputs change only at the falling edge; each falling
    // edge gets at most one assignment per signal.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic eof);
        int idle;
        idle = src_steady ? 0 : pick_gap();
        repeat (idle) begin
            @(negedge aclk);
            s_valid       <= 1'b0;
            s_data_byte   <= 8'($urandom);    // payload is don't-care while idle
            s_end_of_file <= 1'($urandom);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_file <= eof;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_queued();
        logic [8:0] beat;
        while (beat_q.size() != 0) begin
            beat = beat_q.pop_front();
            send_beat(beat[7:0], beat[8]);
        end
    endtask

    // Sender pause: drop valid and wait until every predicted result is in.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ledger.awaited_tokens.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Text builders: append bytes to beat_q.
    // ------------------------------------------------------------------
    task automatic put(input logic [7:0] b);
        beat_q.push_back({1'b0, b});
    endtask

    task automatic put_eof();
        beat_q.push_back({1'b1, 8'($urandom)});
    endtask

    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    // A byte that is stored as a word character (any code but zero, tab, LF, CR, space, quote and comma).
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 4) == 0)
                c = 8'($urandom_range(1, 255));
            else
                c = 8'($urandom_range(33, 126));
        end while (c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE ||
                   c == CH_QUOTE || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_COMMA;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 7))
            0:       return CH_NUL;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return CH_SPACE;
            5:       return CH_QUOTE;
            6:       return CH_COMMA;
            default: return CH_SEMI;
        endcase
    endfunction

    task automatic add_seps();
        repeat ($urandom_range(1, 3)) put(sep_byte());
    endtask

    // Plain word, quoted word holding separators, quotes-only word, or a word with an empty quote pair inside.
    task automatic add_word(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            put(CH_QUOTE);
            put(CH_QUOTE);
        end else if (r < 20) begin
            put(CH_QUOTE);
            repeat (len) put(($urandom_range(0, 4) == 0) ? sep_byte() : word_byte());
            put(CH_QUOTE);
        end else begin
            repeat (len) put(word_byte());
            if (r < 25) begin
                put(CH_QUOTE);
                put(CH_QUOTE);
                put(word_byte());
            end
        end
    endtask

    task automatic add_words();
        int n, i;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0)
            add_seps();
        for (i = 0; i < n; i++) begin
            add_word($urandom_range(1, 8));
            if (i < n - 1 || $urandom_range(0, 4) == 0)
                add_seps();
        end
    endtask

    // LF, CR LF, or CR followed by a byte it swallows (word byte, CR, zero).
    task automatic add_line_break();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            put(CH_LF);
        end else begin
            put(CH_CR);
            case (r)
                5, 6:    put(CH_LF);
                7:       put(word_byte());
                8:       put(CH_CR);
                default: put(CH_NUL);
            endcase
        end
    endtask

    task automatic add_comment();
        logic [7:0] c;
        put(CH_SEMI);
        repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom);
            if (c == CH_LF || c == CH_CR || c == CH_NUL)
                c = CH_SEMI;
            put(c);
        end
        case ($urandom_range(0, 2))
            0:       put(CH_LF);
            1:       begin put(CH_CR); put(8'($urandom)); end
            default: put(CH_NUL);
        endcase
    endtask

    // More than LINE_CAP bytes of short words: the tail is dropped.
    task automatic add_long_line();
        int count;
        count = 0;
        while (count < 300) begin
            repeat (8) put(word_byte());
            put(sep_byte());
            count += 9;
        end
        add_line_break();
    endtask

    // One word past the word limit, then the line limit is hit too.
    task automatic add_long_word();
        repeat (270) put(word_byte());
        put(CH_SPACE);
        put(word_byte());
        put(CH_LF);
    endtask

    task automatic add_random_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            add_words();
            add_line_break();
        end else if (r < 65) begin
            add_comment();
        end else if (r < 72) begin
            repeat ($urandom_range(1, 3)) add_line_break();
        end else if (r < 82) begin
            // noise: any byte, controls weighted up, rare end of file
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 19))
                    0:                   put_eof();
                    1, 2, 3, 4, 5, 6:    put(8'($urandom));
                    7, 8, 9, 10, 11, 12: put(special_byte());
                    default:             put(word_byte());
                endcase
            end
        end else if (r < 92) begin
            // unterminated line closed by a zero byte or end of file
            add_words();
            if ($urandom_range(0, 1) == 0)
                put(CH_NUL);
            else
                put_eof();
        end else begin
            // end of file in an awkward state, or quoting left open at line end
            case ($urandom_range(0, 2))
                0: begin put(CH_SEMI); put(word_byte()); put_eof(); end
                1: begin put(word_byte()); put(CH_CR); put_eof(); end
                default: begin put(CH_QUOTE); add_words(); add_line_break(); end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed text, random text, drain, verdict.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int seq;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'h00;
        s_end_of_file = 1'b0;
        src_steady    = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed text
        put(CH_LF);                                   // empty line: counted, no result
        put_str("A"); put(8'hFF); put(8'h01);         // character extremes
        put(CH_COMMA);                                // word end, length 3
        put(CH_TAB); put(CH_SPACE);                   // separators with no word open
        put(CH_QUOTE); put(CH_SPACE); put_str("q"); put(CH_QUOTE); // quoted space kept
        put(CH_SPACE);                                // word end, length 2
        put(CH_QUOTE); put(CH_QUOTE);                 // quotes-only word: no word end
        put(CH_LF);                                   // line end
        put(CH_SEMI); put_str("x"); put(CH_NUL);      // zero ends the comment only
        put_str("b"); put(CH_CR); put(CH_NUL);        // zero after CR is swallowed
        put_str("c"); put(CH_NUL);                    // end of data with word pending
        put(CH_SEMI); put_str("y"); put_eof();        // end of file inside a comment
        put_str("d"); put(CH_CR); put_eof();          // end of file with swallow pending
        send_queued();
        wait_drained();

        // random text, mostly well-formed lines with random content
        seq = 0;
        while (ledger.bytes_taken < ITEMS_TARGET) begin
            src_steady = ($urandom_range(0, 5) == 0);
            if (seq == 5 || $urandom_range(0, 149) == 0)
                add_long_line();
            else if (seq == 20 || $urandom_range(0, 149) == 0)
                add_long_word();
            else
                add_random_text();
            send_queued();
            seq++;
            if (seq % 25 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge aclk);    // catch any stray result beat

        $display("covered %0d input beats (%0d acted on) and %0d result beats",
                 ledger.bytes_taken, ledger.bytes_taken - ledger.bytes_ignored,
                 ledger.tokens_seen);
        $display("  %0d word ends, %0d line ends, %0d ends of data, %0d with overflow, %0d mismatches",
                 ledger.words_seen, ledger.lines_seen, ledger.ends_seen,
                 ledger.overflow_tokens, ledger.mismatches);
        if (ledger.failed()) begin
            $display("CHECKS FAILED");
        end else begin
            $display("ALL CHECKS PASSED");
        end
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial begin : watchdog
        #(8 * 1000000);
        $display("timeout: beats stopped moving");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/cltok_pkg.sv
hdl/cltok_core.sv
hdl/cltok_obuf.sv
hdl/config_text_line_word_tokenizer.sv
tb/testbench.sv
